### hdl/wmfd_pkg.sv
// ----------------------------------------------------------------------------
// wmfd_pkg: shared definitions for the windowed maximum fan duty block
// Widths, register indexes, reset values and controller/datapath bundles.
// ----------------------------------------------------------------------------
package wmfd_pkg;

  // Sample ring depth
  localparam int WINDOW = 8;
  localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW     = $clog2(WINDOW + 1);

  localparam int TEMP_W = 19;
  localparam int DUTY_W = 10;

  // (c - lo) * (duty_max - duty_min), and 2 * num + den
  localparam int PROD_W = TEMP_W + 1 + DUTY_W + 1;
  localparam int NW     = PROD_W + 2;

  // Rounded quotient magnitude is always below 2^QBITS
  localparam int QBITS  = DUTY_W + 1;
  localparam int QCW    = $clog2(QBITS);

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_MIN  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_MAX  = 2'd3;

  // Reset values
  localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = 19'sd50000;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 19'sd60000;
  localparam logic [DUTY_W-1:0]        DUTY_MIN_RST  = 10'd256;
  localparam logic [DUTY_W-1:0]        DUTY_MAX_RST  = 10'd1023;
  localparam logic [DUTY_W-1:0]        LAST_DUTY_RST = 10'd1023;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // store accepted sample, restart scan
    logic scan_rd;   // read next ring entry
    logic map;       // clamp and multiply
    logic prep;      // form numerator and divisor
    logic div_step;  // one restoring division step
    logic commit;    // load output register and last duty
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done; // all filled entries have been read
    logic div_last;  // final division step in progress
    logic duty_new;  // computed duty differs from last one sent
  } sts_t;

endpackage

### hdl/wmfd_dpath.sv
// ----------------------------------------------------------------------------
// wmfd_dpath: datapath of the windowed maximum fan duty block
// Config registers, sample ring, max scan, linear map and serial divider.
// ----------------------------------------------------------------------------
module wmfd_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wmfd_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wmfd_pkg::TEMP_W-1:0]         cfg_wdata_i,
  input  logic signed [wmfd_pkg::TEMP_W-1:0]  temp_sample_i,
  input  wmfd_pkg::cmd_t                      cmd_i,
  output wmfd_pkg::sts_t                      sts_o,
  output logic [wmfd_pkg::DUTY_W-1:0]         fan_duty_o,
  output logic signed [wmfd_pkg::TEMP_W-1:0]  window_peak_o
);
  import wmfd_pkg::*;

  logic signed [TEMP_W-1:0] lo_q, hi_q;
  logic [DUTY_W-1:0]        dmin_q, dmax_q;

  logic signed [TEMP_W-1:0] ring_mem [WINDOW];
  logic signed [TEMP_W-1:0] rd_data_q;
  logic                     rd_vld_q, rd_first_q;
  logic [AW-1:0]            wslot_q;
  logic [CW-1:0]            fill_q, scan_idx_q;
  logic signed [TEMP_W-1:0] peak_q;

  logic signed [TEMP_W-1:0] clamp_c;
  logic signed [TEMP_W:0]   span, den_d;
  logic signed [DUTY_W:0]   dd;
  logic signed [PROD_W-1:0] prod_d, num_q;
  logic signed [TEMP_W:0]   den_q;
  logic                     degen_q;

  logic signed [NW-1:0]     nsum;
  logic [NW-1:0]            rem_q, dsh_q;
  logic [QBITS-1:0]         quot_q;
  logic                     neg_q;
  logic [QCW-1:0]           cnt_q;
  logic                     ge;

  logic signed [QBITS:0]    qs;
  logic [QBITS:0]           dsum;
  logic [DUTY_W-1:0]        duty_res, last_q, fan_duty_q;
  logic signed [TEMP_W-1:0] peak_out_q;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= TEMP_LOW_RST;
      hi_q   <= TEMP_HIGH_RST;
      dmin_q <= DUTY_MIN_RST;
      dmax_q <= DUTY_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP_LOW:  lo_q   <= cfg_wdata_i;
        REG_TEMP_HIGH: hi_q   <= cfg_wdata_i;
        REG_DUTY_MIN:  dmin_q <= cfg_wdata_i[DUTY_W-1:0];
        REG_DUTY_MAX:  dmax_q <= cfg_wdata_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample ring, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ring_mem[wslot_q] <= temp_sample_i;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= ring_mem[scan_idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q    <= '0;
      fill_q     <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.scan_rd;
      rd_first_q <= cmd_i.scan_rd && (scan_idx_q == '0);
      if (cmd_i.load) begin
        wslot_q    <= (wslot_q == AW'(WINDOW - 1)) ? '0 : wslot_q + 1'b1;
        scan_idx_q <= '0;
        if (fill_q != CW'(WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
      end else if (cmd_i.scan_rd) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (rd_first_q || (rd_data_q > peak_q))) begin
      peak_q <= rd_data_q;
    end
  end

  // Clamp and multiply
  always_comb begin
    if (peak_q < lo_q) begin
      clamp_c = lo_q;
    end else if (peak_q > hi_q) begin
      clamp_c = hi_q;
    end else begin
      clamp_c = peak_q;
    end
  end

  assign span   = {clamp_c[TEMP_W-1], clamp_c} - {lo_q[TEMP_W-1], lo_q};
  assign den_d  = {hi_q[TEMP_W-1], hi_q} - {lo_q[TEMP_W-1], lo_q};
  assign dd     = $signed({1'b0, dmax_q}) - $signed({1'b0, dmin_q});
  assign prod_d = span * dd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      num_q   <= prod_d;
      den_q   <= den_d;
      degen_q <= !(hi_q > lo_q);
    end
  end

  // Floor division of 2*num + den by 2*den, one quotient bit a cycle
  assign nsum = {num_q[PROD_W-1], num_q, 1'b0}
              + {{(NW-TEMP_W-1){den_q[TEMP_W]}}, den_q};
  assign ge   = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      neg_q  <= nsum[NW-1];
      rem_q  <= nsum[NW-1] ? NW'(-nsum) : NW'(nsum);
      dsh_q  <= {{(NW-TEMP_W-1){1'b0}}, den_q[TEMP_W-1:0], 1'b0} << (QBITS - 1);
      quot_q <= '0;
      cnt_q  <= QCW'(QBITS - 1);
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[QBITS-2:0], ge};
      dsh_q  <= dsh_q >> 1;
      cnt_q  <= cnt_q - 1'b1;
    end
  end

  // Negative numerator rounds toward minus infinity
  always_comb begin
    if (neg_q) begin
      qs = -$signed({1'b0, quot_q}) - $signed({{QBITS{1'b0}}, (rem_q != '0)});
    end else begin
      qs = $signed({1'b0, quot_q});
    end
  end

  assign dsum     = {{(QBITS+1-DUTY_W){1'b0}}, dmin_q} + $unsigned(qs);
  assign duty_res = degen_q ? dmax_q : dsum[DUTY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= LAST_DUTY_RST;
    end else if (cmd_i.commit) begin
      last_q <= duty_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      fan_duty_q <= duty_res;
      peak_out_q <= peak_q;
    end
  end

  assign sts_o.scan_done = (scan_idx_q == fill_q);
  assign sts_o.div_last  = (cnt_q == '0);
  assign sts_o.duty_new  = (duty_res != last_q);

  assign fan_duty_o    = fan_duty_q;
  assign window_peak_o = peak_out_q;

endmodule

### hdl/wmfd_ctrl.sv
// ----------------------------------------------------------------------------
// wmfd_ctrl: sequencer of the windowed maximum fan duty block
// Steps scan, map and divide; owns the request handshakes and output valid.
// ----------------------------------------------------------------------------
module wmfd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  wmfd_pkg::sts_t sts_i,
  output wmfd_pkg::cmd_t cmd_o
);
  import wmfd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_done) begin
          cmd_o.scan_rd = 1'b1;
        end else begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.duty_new) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/windowed_max_fan_duty.sv
// ----------------------------------------------------------------------------
// windowed_max_fan_duty: fan PWM duty from the peak of recent temperatures
// Sequence per request: accept in idle, ring scan of the filled entries
// (one memory read port), multiply, divider setup, 11 divider steps, finish;
// the next request is accepted only after finish returns to idle.
// Reset (async, active low): ring empty, write slot 0, last duty 1023,
// thresholds 50000/60000, duty range 256..1023; ring contents stay unknown.
// ----------------------------------------------------------------------------
module windowed_max_fan_duty (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [wmfd_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wmfd_pkg::TEMP_W-1:0]         cfg_wdata_i,
  // sample request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [wmfd_pkg::TEMP_W-1:0]  temp_sample_i,
  // duty request channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wmfd_pkg::DUTY_W-1:0]         fan_duty_o,
  output logic signed [wmfd_pkg::TEMP_W-1:0]  window_peak_o
);
  import wmfd_pkg::*;

  // Controller and datapath talk only through these two bundles.
  cmd_t cmd;
  sts_t sts;

  // The controller accepts a sample only in idle, but the output register
  // decouples it from the consumer: a new sample can be taken while the
  // previous duty still waits. Finish stalls only if a new duty must be
  // written while the old one is still pending.
  wmfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: ring write on accept, scan filled entries for the peak,
  // clamp, multiply by the duty span, then a restoring divide by twice the
  // threshold span with floor rounding for a falling slope. Equal duty is dropped.
  wmfd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .temp_sample_i (temp_sample_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .fan_duty_o    (fan_duty_o),
    .window_peak_o (window_peak_o)
  );

  // A committed duty always differs from the last one sent.
  a_commit_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.duty_new)
    else $error("duty committed without a change");

  // Never overwrite a pending result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && out_valid_o) |-> out_ready_i)
    else $error("pending result overwritten");

  // One sample in flight: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second sample accepted while busy");

  // A commit raises output valid on the next cycle.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("commit did not present a result");

endmodule

### tb/windowed_max_fan_duty_test.sv
// ----------------------------------------------------------------------------
// windowed_max_fan_duty_test: self-checking bench for the fan duty block
// Sends temperature samples and register settings, predicts each duty update
// from a cycle-free model of the sample window and linear map, and checks every
// update the block returns. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module windowed_max_fan_duty_test;
  import wmfd_pkg::*;

  // Cycles in which nothing moves before the run is declared hung. This is far
  // above the slowest correct stretch (settle + register writes + sender gap
  // + a full scan and divide).
  localparam int WATCHDOG_LIMIT = 2000;
  // Lets any sample still in flight finish.
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 10;

  // One duty update as the block reports it
  typedef struct {
    logic [DUTY_W-1:0]        duty;
    logic signed [TEMP_W-1:0] peak;
  } duty_update_t;

  // Tracks the sample window and thresholds, predicts duty updates and checks
  // the ones coming out of the block in order.
  class duty_tracker;
    logic signed [TEMP_W-1:0] window_q[WINDOW];
    int                       write_slot;
    int                       fill_count;
    logic [DUTY_W-1:0]        last_duty;
    logic signed [TEMP_W-1:0] temp_low;
    logic signed [TEMP_W-1:0] temp_high;
    logic [DUTY_W-1:0]        duty_min;
    logic [DUTY_W-1:0]        duty_max;
    duty_update_t             pending_updates[$];
    int                       mismatches;
    int                       updates_checked;

    function new();
      write_slot      = 0;
      fill_count      = 0;
      last_duty       = LAST_DUTY_RST;
      temp_low        = TEMP_LOW_RST;
      temp_high       = TEMP_HIGH_RST;
      duty_min        = DUTY_MIN_RST;
      duty_max        = DUTY_MAX_RST;
      mismatches      = 0;
      updates_checked = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [TEMP_W-1:0] data);
      case (idx)
        REG_TEMP_LOW:  temp_low  = data;
        REG_TEMP_HIGH: temp_high = data;
        REG_DUTY_MIN:  duty_min  = data[DUTY_W-1:0];
        REG_DUTY_MAX:  duty_max  = data[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp, then map linearly with floor(x + 1/2) rounding in exact integers
    function logic [DUTY_W-1:0] map_duty(logic signed [TEMP_W-1:0] peak);
      longint lo, hi, c, d_lo, d_hi, num, den, q;
      lo   = temp_low;
      hi   = temp_high;
      c    = peak;
      d_lo = duty_min;
      d_hi = duty_max;
      if (hi <= lo) return duty_max;
      if (c < lo) c = lo;
      else if (c > hi) c = hi;
      den = 2 * (hi - lo);
      num = 2 * (c - lo) * (d_hi - d_lo) + (hi - lo);
      q   = num / den;
      if (num < 0 && (num % den) != 0) q--;
      return DUTY_W'(d_lo + q);
    endfunction

    function void take_sample(logic signed [TEMP_W-1:0] temp);
      logic signed [TEMP_W-1:0] peak;
      logic [DUTY_W-1:0]        duty;
      duty_update_t             upd;
      window_q[write_slot] = temp;
      write_slot = (write_slot + 1) % WINDOW;
      if (fill_count < WINDOW) fill_count++;
      peak = window_q[0];
      for (int i = 1; i < fill_count; i++)
        if (window_q[i] > peak) peak = window_q[i];
      duty = map_duty(peak);
      if (duty != last_duty) begin
        last_duty = duty;
        upd.duty  = duty;
        upd.peak  = peak;
        pending_updates.push_back(upd);
      end
    endfunction

    function void check_update(logic [DUTY_W-1:0] duty, logic signed [TEMP_W-1:0] peak);
      duty_update_t want;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected duty update: duty=%0d peak=%0d", $time, duty, peak);
        mismatches++;
        return;
      end
      want = pending_updates.pop_front();
      updates_checked++;
      if (duty !== want.duty) begin
        $display("%0t: fan_duty mismatch: expected %0d, got %0d", $time, want.duty, duty);
        mismatches++;
      end
      if (peak !== want.peak) begin
        $display("%0t: window_peak mismatch: expected %0d, got %0d",
                 $time, want.peak, peak);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_updates.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block ports, inputs all known from time zero
  // --------------------------------------------------------------------------
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_idx_i     = REG_TEMP_LOW;
  logic [TEMP_W-1:0]        cfg_wdata_i   = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic signed [TEMP_W-1:0] temp_sample_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic [DUTY_W-1:0]        fan_duty_o;
  logic signed [TEMP_W-1:0] window_peak_o;

  duty_tracker tracker = new();

  bit tx_idle_on = 1'b1;   // sender inserts random gaps
  bit rx_idle_on = 1'b1;   // receiver inserts random stalls
  int rx_stall   = 0;
  int idle_cycles = 0;
  int samples_sent = 0;
  int configs_used = 1;    // reset setting counts as the first

  windowed_max_fan_duty DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .temp_sample_i (temp_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fan_duty_o    (fan_duty_o),
    .window_peak_o (window_peak_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Duty side: take updates and, when enabled, stall at random after each one.
  // Values are sampled at the edge, before the block's flops update.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        tracker.check_update(fan_duty_o, window_peak_o);
        rx_stall = rx_idle_on ? int'($urandom_range(0, 19)) : 0;
      end
      if (rx_stall > 0) begin
        out_ready_i <= 1'b0;
        rx_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: any request moving on either channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no request moved for %0d cycles, %0d updates outstanding",
               $time, idle_cycles, tracker.pending());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------
  // Valid is only lowered when a gap is drawn, so back-to-back requests never
  // see a low and a high assignment in the same step.
  task automatic send_sample(input logic [TEMP_W-1:0] temp);
    int gap;
    gap = tx_idle_on ? int'($urandom_range(0, 19)) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    temp_sample_i <= temp;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_sample(temp);
    samples_sent++;
  endtask

  // Wait for all predicted updates, then for any sample still being worked on
  // that produces no update.
  task automatic wait_idle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four registers back to back; duty writes carry random junk in
  // the unused upper bits, which the block must ignore.
  task automatic write_config(input int lo, input int hi, input int dmin, input int dmax);
    logic [REG_IDX_W-1:0] idx[4];
    logic [TEMP_W-1:0]    data[4];
    idx[0]  = REG_TEMP_LOW;
    idx[1]  = REG_TEMP_HIGH;
    idx[2]  = REG_DUTY_MIN;
    idx[3]  = REG_DUTY_MAX;
    data[0] = TEMP_W'(lo);
    data[1] = TEMP_W'(hi);
    data[2] = {9'($urandom), DUTY_W'(dmin)};
    data[3] = {9'($urandom), DUTY_W'(dmax)};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[k];
      cfg_wdata_i <= data[k];
      @(posedge clk_i);
      tracker.set_reg(idx[k], data[k]);
    end
    cfg_we_i <= 1'b0;
    configs_used++;
  endtask

  // Mostly samples around the active thresholds so the duty actually moves,
  // plus in-spec readings and raw 19-bit patterns.
  function automatic logic [TEMP_W-1:0] draw_temp();
    int lo_v, hi_v, span, a, b, pick, tmp;
    lo_v = tracker.temp_low;
    hi_v = tracker.temp_high;
    if (lo_v > hi_v) begin
      tmp  = lo_v;
      lo_v = hi_v;
      hi_v = tmp;
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) return TEMP_W'($urandom);
    if (pick < 30) begin
      tmp = $urandom_range(0, 190000);
      return TEMP_W'(tmp - 40000);
    end
    span = hi_v - lo_v;
    a = lo_v - span / 4 - 16;
    b = hi_v + span / 4 + 16;
    if (a < -262144) a = -262144;
    if (b > 262143) b = 262143;
    tmp = $urandom_range(0, b - a);
    return TEMP_W'(a + tmp);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    // Reset setting: full scale sweep, then eight cold samples so the hot
    // one ages out of the window, then points on and around both thresholds
    // including a half-way rounding case (55000 -> 640).
    int warmup[17] = '{-262144, 262143,
                       -40000, -40000, -40000, -40000,
                       -40000, -40000, -40000, -40000,
                       50000, 50001, 55000, 55007, 60000, 59999, 60001};
    // Falling slope: duty_max below duty_min
    int falling[4] = '{61000, 65005, 70000, 80000};
    // Thresholds equal: always duty_max
    int flat[3]    = '{-262144, 30000, 262143};
    int ph_lo[RANDOM_PHASES];
    int ph_hi[RANDOM_PHASES];
    int ph_dmin[RANDOM_PHASES];
    int ph_dmax[RANDOM_PHASES];
    int n_items;

    // Fixed settings first: reset setting, spec extremes, full 19-bit range, one-step band,
    // falling slope, inverted thresholds, zero-width duty range.
    ph_lo = '{50000, -40000, -262144, 20000, -40000, 100000, 0, 0, 0, 0};
    ph_hi = '{60000, 150000, 262143, 20001, 150000, -40000, 0, 0, 0, 0};
    ph_dmin = '{256, 0, 0, 0, 1023, 17, 512, 0, 0, 0};
    ph_dmax = '{1023, 1023, 1023, 1023, 0, 900, 512, 0, 0, 0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (warmup[i]) send_sample(TEMP_W'(warmup[i]));
    in_valid_i <= 1'b0;
    wait_idle();
    write_config(20000, 70000, 1000, 3);
    foreach (falling[i]) send_sample(TEMP_W'(falling[i]));
    in_valid_i <= 1'b0;
    wait_idle();
    write_config(30000, 30000, 5, 700);
    foreach (flat[i]) send_sample(TEMP_W'(flat[i]));
    in_valid_i <= 1'b0;
    wait_idle();

    // Random part, one register setting per phase
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p >= 7) begin
        ph_lo[p]   = int'($urandom_range(0, 190000)) - 40000;
        ph_hi[p]   = int'($urandom_range(0, 190000)) - 40000;
        ph_dmin[p] = $urandom_range(0, 1023);
        ph_dmax[p] = $urandom_range(0, 1023);
      end
      write_config(ph_lo[p], ph_hi[p], ph_dmin[p], ph_dmax[p]);
      // Phase 1 runs with no gaps or stalls at all
      tx_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      n_items = (ph_dmin[p] == ph_dmax[p]) ? 60 : 160;
      for (int i = 0; i < n_items; i++) begin
        send_sample(draw_temp());
        // Hold off mid-phase until every outstanding update is back
        if (i == n_items / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (tracker.pending() != 0);
        end
      end
      in_valid_i <= 1'b0;
      wait_idle();
    end

    $display("Sent %0d samples over %0d register settings; %0d duty updates checked,",
             samples_sent, configs_used, tracker.updates_checked);
    $display("%0d mismatches found.", tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
